// File: rtl/eqgal_pkg.sv
`default_nettype none
package eqgal_pkg;
   localparam int AMP_BITS = 34;
   localparam int FRAC_BITS = 30;
   localparam logic signed [AMP_BITS-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [31:0] RST_POLE_DEC = 32'd323530342;
   localparam logic [31:0] RST_NODE_RA = 32'd3374651248;
   localparam logic [31:0] RST_LON_OFFSET = 32'd392870203;
   localparam logic [1:0] REG_POLE_DEC = 2'd0;
   localparam logic [1:0] REG_NODE_RA = 2'd1;
   localparam logic [1:0] REG_LON_OFFSET = 2'd2;

   // atan(2^-i) as a fraction of a turn, scaled by 2^64
   function automatic logic [63:0] atan_turn64(input int i);
      logic [63:0] t [0:47];
      t[0]=64'h2000000000000000; t[1]=64'h12E4051D9DF30800;
      t[2]=64'h09FB385B5EE39E80; t[3]=64'h051111D41DDD9A00;
      t[4]=64'h028B0D430E589B00; t[5]=64'h0145D7E159046280;
      t[6]=64'h00A2F61E5C282640; t[7]=64'h00517C5511D442B0;
      t[8]=64'h0028BE5346D0C338; t[9]=64'h00145F2EBB30AB38;
      t[10]=64'h000A2F980091BA7C; t[11]=64'h000517CC14A80CB7;
      t[12]=64'h00028BE60CDFEC62; t[13]=64'h000145F306C172F2;
      t[14]=64'h0000A2F9836AE913; t[15]=64'h0000517CC1B6BA7C;
      t[16]=64'h000028BE60DB8D41; t[17]=64'h0000145F306DC81B;
      t[18]=64'h00000A2F9836E4AD; t[19]=64'h00000517CC1B7271;
      t[20]=64'h0000028BE60DB939; t[21]=64'h00000145F306DC9C;
      t[22]=64'h000000A2F9836E4E; t[23]=64'h000000517CC1B727;
      t[24]=64'h00000028BE60DB93; t[25]=64'h000000145F306DC9;
      t[26]=64'h0000000A2F9836E4; t[27]=64'h0000000517CC1B72;
      t[28]=64'h000000028BE60DB9; t[29]=64'h0000000145F306DC;
      t[30]=64'h00000000A2F9836E; t[31]=64'h00000000517CC1B7;
      t[32]=64'h0000000028BE60DB; t[33]=64'h00000000145F306D;
      t[34]=64'h000000000A2F9836; t[35]=64'h000000000517CC1B;
      t[36]=64'h00000000028BE60D; t[37]=64'h000000000145F306;
      t[38]=64'h0000000000A2F983; t[39]=64'h0000000000517CC1;
      t[40]=64'h000000000028BE60; t[41]=64'h0000000000145F30;
      t[42]=64'h00000000000A2F98; t[43]=64'h00000000000517CC;
      t[44]=64'h0000000000028BE6; t[45]=64'h00000000000145F3;
      t[46]=64'h000000000000A2F9; t[47]=64'h000000000000517C;
      return t[i];
   endfunction

   function automatic logic signed [AMP_BITS-1:0] asr(
      input logic signed [AMP_BITS-1:0] v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [AMP_BITS-1:0] qmul(
      input logic signed [AMP_BITS-1:0] a, input logic signed [AMP_BITS-1:0] b);
      logic signed [2*AMP_BITS-1:0] p;
      p = a * b + (68'sd1 <<< (FRAC_BITS - 1));
      return AMP_BITS'(p >>> FRAC_BITS);
   endfunction
endpackage
`default_nettype wire

// File: rtl/eqgal_rot_cell.sv
`default_nettype none
// one cordic micro-rotation; mode 0 rotates z to zero, mode 1 drives y to zero
module eqgal_rot_cell #(
   parameter int ANGLE_BITS = 32,
   parameter int STEP = 0,
   parameter bit VECTORING = 1'b0
) (
   input  wire logic clock,
   input  wire logic signed [eqgal_pkg::AMP_BITS-1:0] x_in,
   input  wire logic signed [eqgal_pkg::AMP_BITS-1:0] y_in,
   input  wire logic signed [ANGLE_BITS:0] z_in,
   output logic signed [eqgal_pkg::AMP_BITS-1:0] x_out,
   output logic signed [eqgal_pkg::AMP_BITS-1:0] y_out,
   output logic signed [ANGLE_BITS:0] z_out
);
   localparam logic [63:0] RAW = eqgal_pkg::atan_turn64(STEP);
   localparam logic [64:0] RND = (STEP == 0) ? {1'b0, RAW} :
      ({1'b0, RAW} + (65'd1 << (63 - ANGLE_BITS)));
   localparam logic signed [ANGLE_BITS:0] ATAN =
      (ANGLE_BITS+1)'(RND[64:64-ANGLE_BITS]);
   logic signed [eqgal_pkg::AMP_BITS-1:0] x_ff, y_ff, dx, dy;
   logic signed [ANGLE_BITS:0] z_ff;
   logic up;
   always_comb begin
      dx = eqgal_pkg::asr(y_in, STEP);
      dy = eqgal_pkg::asr(x_in, STEP);
      up = VECTORING ? (y_in >= 0) : (z_in >= 0);
   end
   always_ff @(posedge clock) begin
      if (up ^ VECTORING) begin
         x_ff <= x_in - dx;
         y_ff <= y_in + dy;
      end else begin
         x_ff <= x_in + dx;
         y_ff <= y_in - dy;
      end
      if (up) z_ff <= z_in - (VECTORING ? -ATAN : ATAN);
      else    z_ff <= z_in + (VECTORING ? -ATAN : ATAN);
   end
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

// File: rtl/eqgal_cordic.sv
`default_nettype none
// chain of cells with pre-fold and passthrough of side data
module eqgal_cordic #(
   parameter int ANGLE_BITS = 32,
   parameter int CORDIC_STEPS = 32,
   parameter bit VECTORING = 1'b0,
   parameter int SIDE_BITS = 1
) (
   input  wire logic clock,
   input  wire logic signed [eqgal_pkg::AMP_BITS-1:0] x_in,
   input  wire logic signed [eqgal_pkg::AMP_BITS-1:0] y_in,
   input  wire logic [ANGLE_BITS-1:0] t_in,
   input  wire logic [SIDE_BITS-1:0] side_in,
   output logic signed [eqgal_pkg::AMP_BITS-1:0] x_out,
   output logic signed [eqgal_pkg::AMP_BITS-1:0] y_out,
   output logic [ANGLE_BITS-1:0] t_out,
   output logic [SIDE_BITS-1:0] side_out
);
   localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] QTR = {2'b01, {(ANGLE_BITS-2){1'b0}}};
   logic signed [eqgal_pkg::AMP_BITS-1:0] xs [0:CORDIC_STEPS];
   logic signed [eqgal_pkg::AMP_BITS-1:0] ys [0:CORDIC_STEPS];
   logic signed [ANGLE_BITS:0] zs [0:CORDIC_STEPS];
   logic [SIDE_BITS-1:0] sd [0:CORDIC_STEPS];
   logic flip [0:CORDIC_STEPS];
   logic zero [0:CORDIC_STEPS];
   logic [ANGLE_BITS-1:0] tf;
   logic fl;
   always_comb begin
      fl = 1'b0;
      tf = t_in;
      if (VECTORING) fl = x_in < 0;
      else begin
         fl = (t_in + QTR) >= HALF;
         if (fl) tf = t_in - HALF;
      end
   end
   // stage 0: fold into the right half plane
   always_ff @(posedge clock) begin
      sd[0] <= side_in;
      flip[0] <= fl;
      zero[0] <= (x_in == 0) && (y_in == 0);
      if (VECTORING) begin
         xs[0] <= fl ? -x_in : x_in;
         ys[0] <= fl ? -y_in : y_in;
         zs[0] <= fl ? {1'b0, HALF} : '0;
      end else begin
         xs[0] <= eqgal_pkg::GAIN_Q30;
         ys[0] <= '0;
         zs[0] <= {tf[ANGLE_BITS-1], tf};
      end
   end
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      logic signed [ANGLE_BITS:0] zn;
      eqgal_rot_cell #(.ANGLE_BITS(ANGLE_BITS), .STEP(i), .VECTORING(VECTORING)) u_cell (
         .clock(clock), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
         .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zn));
      // vectoring angle wraps modulo a turn, rotation residue stays small
      assign zs[i+1] = VECTORING ? {1'b0, zn[ANGLE_BITS-1:0]} : zn;
      always_ff @(posedge clock) begin
         sd[i+1] <= sd[i];
         flip[i+1] <= flip[i];
         zero[i+1] <= zero[i];
      end
   end
   always_comb begin
      side_out = sd[CORDIC_STEPS];
      t_out = zs[CORDIC_STEPS][ANGLE_BITS-1:0];
      x_out = xs[CORDIC_STEPS];
      y_out = ys[CORDIC_STEPS];
      if (VECTORING) begin
         if (zero[CORDIC_STEPS]) begin
            t_out = '0;
            x_out = '0;
         end
      end else if (flip[CORDIC_STEPS]) begin
         x_out = -xs[CORDIC_STEPS];
         y_out = -ys[CORDIC_STEPS];
      end
   end
endmodule
`default_nettype wire

// File: rtl/equatorial_to_galactic_coords.sv
`default_nettype none
// equatorial to galactic conversion, fully pipelined: one word in and one
// word out per clock once the pipe is full and no stall holds it. the
// stages from input handshake to the result buffer are three cordic
// chains of CORDIC_STEPS+1 stages each (sine/cosine, longitude vectoring,
// latitude vectoring), two product stages and one stage between the vectoring
// chains, then the result buffer and its head register. the cordic cells run
// freely and never stall; finished words wait in a result buffer deep enough
// for every word in flight, and req_ready drops only once that many words are
// in flight, so a stalled receiver first fills the buffer and then holds input.
// angles are binary: a full turn is 2^32 on the ports, ANGLE_BITS inside.
// csr writes take effect on the next accepted word; write only while idle.
module equatorial_to_galactic_coords #(
   parameter int ANGLE_BITS = 32,
   parameter int CORDIC_STEPS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [31:0] req_ra,
   input  wire logic signed [31:0] req_dec,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_gal_lon,
   output logic signed [31:0] rsp_gal_lat,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [3:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int AB = eqgal_pkg::AMP_BITS;
   // register stages from the input edge to a finished result
   localparam int LAT = 3 * (CORDIC_STEPS + 1) + 3;
   // buffer slots: enough for every word in flight at full rate
   localparam int BD = LAT + 3;
   localparam int PW = $clog2(BD);
   localparam int CW = $clog2(BD + 1);

   // csr registers
   logic [30:0] pole_dec_ff;
   logic [31:0] node_ra_ff, lon_offset_ff;
   logic [1:0] csr_idx;
   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[3:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         pole_dec_ff <= eqgal_pkg::RST_POLE_DEC[30:0];
         node_ra_ff <= eqgal_pkg::RST_NODE_RA;
         lon_offset_ff <= eqgal_pkg::RST_LON_OFFSET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[1]) begin
         priority case (csr_idx)
            eqgal_pkg::REG_POLE_DEC:   pole_dec_ff <= csr_pwdata[30:0];
            eqgal_pkg::REG_NODE_RA:    node_ra_ff <= csr_pwdata;
            eqgal_pkg::REG_LON_OFFSET: lon_offset_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_idx)
         eqgal_pkg::REG_POLE_DEC:   csr_prdata = {1'b0, pole_dec_ff};
         eqgal_pkg::REG_NODE_RA:    csr_prdata = node_ra_ff;
         eqgal_pkg::REG_LON_OFFSET: csr_prdata = lon_offset_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // the cells are free-running registers; a valid bit rides beside each
   // stage, and input stalls when the in-flight count reaches the buffer size
   logic [LAT-1:0] vld_ff;
   logic [CW-1:0] cnt_ff;
   logic push, pop;
   // output buffer deep enough for every word in flight
   logic [63:0] buf_mem [0:BD-1];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] fill_ff;
   logic [31:0] lon_res;
   logic signed [31:0] lat_res;

   function automatic logic [ANGLE_BITS-1:0] to_inner(input logic [31:0] v);
      logic [63:0] w;
      w = {v, 32'd0};
      return ANGLE_BITS'(w >> (64 - ANGLE_BITS));
   endfunction
   function automatic logic [31:0] to_outer(input logic [ANGLE_BITS-1:0] v);
      logic [ANGLE_BITS:0] r;
      if (ANGLE_BITS > 32) begin
         r = {1'b0, v} + ((ANGLE_BITS+1)'(1) << (ANGLE_BITS - 33));
         return 32'(r[ANGLE_BITS-1:0] >> (ANGLE_BITS - 32));
      end else return 32'({v, 32'd0} >> ANGLE_BITS);
   endfunction

   // words in flight, including those waiting in the buffer
   assign req_ready = (cnt_ff < CW'(BD));
   assign push = req_valid && req_ready;
   assign pop = rsp_valid && rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], push};
         cnt_ff <= cnt_ff + push - pop;
      end
   end

   // stage a: three sine/cosine chains side by side
   logic signed [AB-1:0] sd, cd, sp, cp, sa, ca;
   logic [ANGLE_BITS-1:0] ta;
   assign ta = to_inner(req_ra) - to_inner(node_ra_ff);
   eqgal_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS),
      .VECTORING(1'b0), .SIDE_BITS(1)) u_sc_dec (
      .clock(clock), .x_in('0), .y_in('0), .t_in(to_inner(req_dec)),
      .side_in(1'b0), .x_out(cd), .y_out(sd), .t_out(), .side_out());
   eqgal_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS),
      .VECTORING(1'b0), .SIDE_BITS(1)) u_sc_pole (
      .clock(clock), .x_in('0), .y_in('0), .t_in(to_inner({1'b0, pole_dec_ff})),
      .side_in(1'b0), .x_out(cp), .y_out(sp), .t_out(), .side_out());
   logic [31:0] off_a;
   eqgal_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS),
      .VECTORING(1'b0), .SIDE_BITS(32)) u_sc_ra (
      .clock(clock), .x_in('0), .y_in('0), .t_in(ta),
      .side_in(lon_offset_ff), .x_out(ca), .y_out(sa), .t_out(), .side_out(off_a));

   // product stages, one multiplier level per register
   logic signed [AB-1:0] t1_ff, sdsp_ff, sdcp_ff, xx_ff, sp1_ff, cp1_ff;
   logic signed [AB-1:0] sinb_ff, yy_ff, xx2_ff;
   logic [31:0] off_p1, off_p2;
   always_ff @(posedge clock) begin
      t1_ff <= eqgal_pkg::qmul(cd, sa);
      sdsp_ff <= eqgal_pkg::qmul(sd, sp);
      sdcp_ff <= eqgal_pkg::qmul(sd, cp);
      xx_ff <= eqgal_pkg::qmul(ca, cd);
      sp1_ff <= sp;
      cp1_ff <= cp;
      off_p1 <= off_a;
      sinb_ff <= sdsp_ff - eqgal_pkg::qmul(cp1_ff, t1_ff);
      yy_ff <= sdcp_ff + eqgal_pkg::qmul(sp1_ff, t1_ff);
      xx2_ff <= xx_ff;
      off_p2 <= off_p1;
   end

   // longitude vectoring chain, sin b rides along
   logic signed [AB-1:0] mag;
   logic [ANGLE_BITS-1:0] dl;
   logic [AB+31:0] side_l;
   eqgal_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS),
      .VECTORING(1'b1), .SIDE_BITS(AB+32)) u_vec_lon (
      .clock(clock), .x_in(xx2_ff), .y_in(yy_ff), .t_in('0),
      .side_in({sinb_ff, off_p2}), .x_out(mag), .y_out(), .t_out(dl),
      .side_out(side_l));

   logic signed [AB-1:0] cosb_ff, sinb2_ff;
   logic [31:0] lon_ff;
   always_ff @(posedge clock) begin
      cosb_ff <= eqgal_pkg::qmul(mag, eqgal_pkg::GAIN_Q30);
      sinb2_ff <= side_l[AB+31:32];
      lon_ff <= to_outer(dl) + side_l[31:0];
   end

   // latitude vectoring chain
   logic [ANGLE_BITS-1:0] bang;
   logic [31:0] lon_b;
   eqgal_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS),
      .VECTORING(1'b1), .SIDE_BITS(32)) u_vec_lat (
      .clock(clock), .x_in(cosb_ff), .y_in(sinb2_ff), .t_in('0),
      .side_in(lon_ff), .x_out(), .y_out(), .t_out(bang), .side_out(lon_b));

   // saturate latitude to a quarter turn
   logic signed [31:0] u;
   always_comb begin
      u = signed'(to_outer(bang));
      if (u > 32'sd1073741824) lat_res = 32'sd1073741824;
      else if (u < -32'sd1073741824) lat_res = -32'sd1073741824;
      else lat_res = u;
      lon_res = lon_b;
   end

   // result buffer: words leave the pipe at fixed latency and wait here
   logic [63:0] head_ff;
   always_ff @(posedge clock) begin
      if (vld_ff[LAT-1]) buf_mem[wp_ff] <= {lon_res, lat_res};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (vld_ff[LAT-1])
            wp_ff <= (wp_ff == PW'(BD-1)) ? '0 : wp_ff + 1'b1;
         if (pop)
            rp_ff <= (rp_ff == PW'(BD-1)) ? '0 : rp_ff + 1'b1;
         fill_ff <= fill_ff + vld_ff[LAT-1] - pop;
      end
   end
   logic [PW-1:0] rnext;
   assign rnext = pop ? ((rp_ff == PW'(BD-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
   always_ff @(posedge clock) head_ff <= buf_mem[rnext];
   // head register is loaded with a fresh write in the cycle after it lands
   logic [CW-1:0] ready_fill_ff;
   always_ff @(posedge clock) begin
      if (reset) ready_fill_ff <= '0;
      else ready_fill_ff <= fill_ff - pop;
   end
   assign rsp_valid = (ready_fill_ff != '0) && (fill_ff != '0);
   assign rsp_gal_lon = head_ff[63:32];
   assign rsp_gal_lat = head_ff[31:0];
endmodule
`default_nettype wire
